>>> hw/rtl/eilb_pkg.sv
// ----------------------------------------------------------------------------
// eilb_pkg
// Shared types, constants and helper functions of the emitter intercept core.
// ----------------------------------------------------------------------------
package eilb_pkg;

  localparam int POSITION_BITS = 40;
  localparam int ANGLE_BITS    = 16;
  localparam int DW            = POSITION_BITS + 2;  // difference and magnitude width
  localparam int LW            = 26;                 // Q16 link sum
  localparam int PW            = 24;                 // unsaturated level
  localparam int RXW           = 18;
  localparam int CXW           = 34;                 // CORDIC x/y

  localparam int LINK_CONST  = 45453;
  localparam int DB_PER_LOG2 = 50504453;

  localparam logic signed [PW-1:0] P_RX_MIN = -24'sd102400;
  localparam logic signed [PW-1:0] P_RX_MAX = 24'sd51200;

  localparam logic [1:0] REG_SENS   = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_CAP    = 2'd2;

  localparam logic [32:0] HITS_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SQ, S_LOGN, S_LOGI, S_LINK, S_THR,
    S_SQRT, S_CPRE, S_CIT, S_DONE
  } eilb_state_t;

  typedef struct packed {
    logic                        det;
    logic [ANGLE_BITS-1:0]       az;
    logic [ANGLE_BITS-1:0]       el;
    logic signed [RXW-1:0]       rx;
  } eilb_res_t;

  function automatic logic [5:0] top_bit64(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // round half up to the output angle width, wrapping
  function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [31:0] acc);
    logic [31:0] s;
    s = acc + (32'd1 << (31 - ANGLE_BITS));
    return s[31 -: ANGLE_BITS];
  endfunction

endpackage

>>> hw/rtl/eilb_engine.sv
// ----------------------------------------------------------------------------
// eilb_engine
// Sequenced datapath: squares, three log2 evaluations and the link product on
// one shared multiplier, then a bit-serial square root and two CORDIC runs.
// ----------------------------------------------------------------------------
module eilb_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [eilb_pkg::DW-1:0]          dx_in,
  input  logic signed [eilb_pkg::DW-1:0]          dy_in,
  input  logic signed [eilb_pkg::DW-1:0]          dz_in,
  input  logic [39:0]                            carrier_in,
  input  logic [39:0]                            tx_in,
  input  logic signed [17:0]                     sens_in,
  input  logic                                   ack,
  output logic                                   done,
  output eilb_pkg::eilb_res_t                    res
);
  import eilb_pkg::*;

  eilb_state_t state, state_next;

  logic signed [DW-1:0] dx, dy, dz;
  logic [39:0]          carrier, tx;
  logic signed [17:0]   sens;
  logic [30:0]          a, b, c, y;
  logic signed [6:0]    t;
  logic [4:0]           cnt;
  logic [1:0]           kidx;
  logic [63:0]          s, hsq, v, r, bb;
  logic [5:0]           lgn;
  logic [15:0]          frac;
  logic signed [LW-1:0] lsum;
  logic signed [PW-1:0] p;
  logic signed [CXW-1:0] cx, cy;
  logic [31:0]          acc;
  logic                 phase_el;
  eilb_res_t            res_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  // comb helpers
  logic [DW-1:0]        ax, ay, azm, mall;
  logic [5:0]           e;
  logic signed [6:0]    t_c, nt;
  logic [30:0]          a_c, b_c, c_c, sq_op;
  logic [63:0]          log_x;
  logic [5:0]           log_n;
  logic [30:0]          log_y;
  logic [31:0]          q;
  logic [15:0]          frac_next;
  logic [22:0]          lg;
  logic signed [65:0]   lsum_rnd;
  logic signed [65:0]   lsum_shr;
  logic signed [PW-1:0] p_c;
  logic [63:0]          rb;
  logic                 ge;
  logic signed [DW-1:0] x_in, y_in, xn, yn, cext, zc;
  logic [DW-1:0]        mxn, myn, mm;
  logic [5:0]           nn;
  logic signed [DW-1:0] xsc, ysc;
  logic                 x_zero, drop, detect;
  logic [31:0]          acc_special;
  logic signed [CXW-1:0] xs, ys;
  logic [31:0]          atan_i, acc_next;

  assign prod = mul_a * mul_b;
  assign done = (state == S_DONE);
  assign res  = res_q;

  always_comb begin
    // magnitudes and common scale
    ax   = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay   = dy[DW-1] ? DW'(-dy) : DW'(dy);
    azm  = dz[DW-1] ? DW'(-dz) : DW'(dz);
    mall = (ax > ay) ? ax : ay;
    if (azm > mall) mall = azm;
    e    = top_bit64(64'(mall));
    t_c  = 7'sd30 - $signed({1'b0, e});
    nt   = -t_c;
    if (t_c >= 0) begin
      a_c = 31'(ax << t_c[4:0]);
      b_c = 31'(ay << t_c[4:0]);
      c_c = 31'(azm << t_c[4:0]);
    end else begin
      a_c = 31'(ax >> nt[4:0]);
      b_c = 31'(ay >> nt[4:0]);
      c_c = 31'(azm >> nt[4:0]);
    end

    drop = (carrier_in == '0) || (tx_in == '0) ||
           ((dx_in == '0) && (dy_in == '0) && (dz_in == '0));

    case (cnt[1:0])
      2'd0:    sq_op = a;
      2'd1:    sq_op = b;
      default: sq_op = c;
    endcase

    // log2 operand and normalisation to top bit 30
    case (kidx)
      2'd0:    log_x = 64'(tx);
      2'd1:    log_x = s;
      default: log_x = 64'(carrier);
    endcase
    log_n = top_bit64(log_x);
    if (log_n >= 6'd30) log_y = 31'(log_x >> (log_n - 6'd30));
    else                log_y = 31'(log_x << (6'd30 - log_n));

    q         = prod[61:30];
    frac_next = frac | (16'(q[31]) << cnt[3:0]);
    lg        = {1'b0, lgn, 16'b0} + 23'(frac_next);

    lsum_rnd = prod + 66'sd2147483648;
    lsum_shr = lsum_rnd >>> 32;
    p_c      = PW'(lsum_shr) + PW'(LINK_CONST);
    detect   = (p >= $signed({{(PW-18){sens[17]}}, sens}));

    // square root step
    rb = r + bb;
    ge = (v >= rb);

    // CORDIC entry
    cext = {{(DW-31){1'b0}}, c};
    zc   = dz[DW-1] ? -cext : cext;
    x_in = phase_el ? {{(DW-33){1'b0}}, r[32:0]} : dx;
    y_in = phase_el ? zc : dy;
    xn   = x_in[DW-1] ? -x_in : x_in;
    yn   = x_in[DW-1] ? -y_in : y_in;
    x_zero = (x_in == '0);
    if (y_in == '0)         acc_special = 32'h0;
    else if (!y_in[DW-1])   acc_special = 32'h40000000;
    else                    acc_special = 32'hC0000000;
    mxn = DW'(xn);
    myn = yn[DW-1] ? DW'(-yn) : DW'(yn);
    mm  = (mxn > myn) ? mxn : myn;
    nn  = top_bit64(64'(mm));
    if (nn > 6'd29) begin
      xsc = xn >>> (nn - 6'd29);
      ysc = yn >>> (nn - 6'd29);
    end else begin
      xsc = xn << (6'd29 - nn);
      ysc = yn << (6'd29 - nn);
    end

    // CORDIC step
    xs     = cx >>> cnt;
    ys     = cy >>> cnt;
    atan_i = atan_entry(cnt);
    acc_next = cy[CXW-1] ? (acc - atan_i) : (acc + atan_i);

    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = $signed({2'b0, sq_op});
        mul_b = $signed({2'b0, sq_op});
      end
      S_LOGI: begin
        mul_a = $signed({2'b0, y});
        mul_b = $signed({2'b0, y});
      end
      S_LINK: begin
        mul_a = 33'(lsum);
        mul_b = 33'(DB_PER_LOG2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = drop ? S_DONE : S_PREP;
      S_PREP: state_next = S_SQ;
      S_SQ:   if (cnt == 5'd2) state_next = S_LOGN;
      S_LOGN: state_next = S_LOGI;
      S_LOGI: if (cnt == 5'd0) state_next = (kidx == 2'd2) ? S_LINK : S_LOGN;
      S_LINK: state_next = S_THR;
      S_THR:  state_next = detect ? S_SQRT : S_DONE;
      S_SQRT: if (cnt == 5'd31) state_next = S_CPRE;
      S_CPRE: begin
        if (!x_zero)      state_next = S_CIT;
        else if (phase_el) state_next = S_DONE;
      end
      S_CIT:  if (cnt == 5'd29) state_next = phase_el ? S_DONE : S_CPRE;
      S_DONE: if (ack) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          dx       <= dx_in;
          dy       <= dy_in;
          dz       <= dz_in;
          carrier  <= carrier_in;
          tx       <= tx_in;
          sens     <= sens_in;
          res_q    <= '0;
          phase_el <= 1'b0;
        end
      end
      S_PREP: begin
        a   <= a_c;
        b   <= b_c;
        c   <= c_c;
        t   <= t_c;
        cnt <= '0;
        s   <= '0;
      end
      S_SQ: begin
        s <= s + prod[63:0];
        if (cnt == 5'd1) hsq <= s + prod[63:0];
        cnt  <= cnt + 5'd1;
        kidx <= '0;
      end
      S_LOGN: begin
        lgn  <= log_n;
        y    <= log_y;
        frac <= '0;
        cnt  <= 5'd15;
      end
      S_LOGI: begin
        y    <= q[31] ? q[31:1] : q[30:0];
        frac <= frac_next;
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          kidx <= kidx + 2'd1;
          case (kidx)
            2'd0: lsum <= $signed({3'b0, lg});
            2'd1: lsum <= lsum - $signed({3'b0, lg}) +
                          ($signed({{(LW-7){t[6]}}, t}) <<< 17);
            default: lsum <= lsum - ($signed({3'b0, lg}) <<< 1);
          endcase
        end
      end
      S_LINK: p <= p_c;
      S_THR: begin
        res_q.det <= detect;
        if (!detect)           res_q.rx <= '0;
        else if (p < P_RX_MIN) res_q.rx <= RXW'(P_RX_MIN);
        else if (p > P_RX_MAX) res_q.rx <= RXW'(P_RX_MAX);
        else                   res_q.rx <= RXW'(p);
        v   <= hsq;
        r   <= '0;
        bb  <= 64'd1 << 62;
        cnt <= '0;
      end
      S_SQRT: begin
        if (ge) begin
          v <= v - rb;
          r <= (r >> 1) + bb;
        end else begin
          r <= r >> 1;
        end
        bb  <= bb >> 2;
        cnt <= cnt + 5'd1;
      end
      S_CPRE: begin
        if (x_zero) begin
          if (phase_el) res_q.el <= to_angle(acc_special);
          else          res_q.az <= to_angle(acc_special);
          phase_el <= 1'b1;
        end else begin
          cx  <= CXW'(xsc);
          cy  <= CXW'(ysc);
          acc <= x_in[DW-1] ? 32'h80000000 : 32'h0;
          cnt <= '0;
        end
      end
      S_CIT: begin
        if (!cy[CXW-1]) begin
          cx <= cx + ys;
          cy <= cy - xs;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
        end
        acc <= acc_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd29) begin
          if (phase_el) res_q.el <= to_angle(acc_next);
          else          res_q.az <= to_angle(acc_next);
          phase_el <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/esm_intercept_link_budget_core.sv
// ----------------------------------------------------------------------------
// esm_intercept_link_budget_core
// Free-space received power, detection, direction of arrival and batch count.
// ----------------------------------------------------------------------------
// One emitter is taken at a time and s_tready stays low until its result has
// moved into the output register. A dropped emitter (zero carrier, power or
// distance) skips the computation, and one below threshold skips the square
// root and the CORDIC runs. An angle whose x input is zero skips its 30 CORDIC
// steps. A result still held on m_* when the next one is ready stalls the
// engine until m_tready frees the output register. A detected emitter passes
// through the three 16-step log2 loops on the shared multiplier, the 32-step
// bit-serial square root and the two 30-step CORDIC runs. The next item is
// accepted while a result still waits on m_*.
module esm_intercept_link_budget_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [30:0]   cfg_wdata,
  input  logic          s_tvalid,
  output logic          s_tready,
  // emitter_tag, emitter_x, emitter_y, emitter_z, sensor_x, sensor_y,
  // sensor_z, carrier_hz, tx_microwatts
  input  logic [351:0]  s_tdata,
  input  logic          s_tlast,
  output logic          m_tvalid,
  input  logic          m_tready,
  // intercept_tag, azimuth, elevation, measured_hz, rx_level, overflow, zero pad
  output logic [127:0]  m_tdata,
  // detected
  output logic          m_tuser,
  output logic          m_tlast
);
  import eilb_pkg::*;

  logic signed [17:0] sens;
  logic signed [30:0] offset;
  logic [15:0]        cap;
  logic               busy;
  logic [31:0]        tag;
  logic [39:0]        carrier;
  logic               last;
  logic [32:0]        hits, hits_new;
  logic               start, eng_done, ack;
  eilb_res_t          eng_res;
  logic signed [DW-1:0] dx, dy, dz;

  logic [31:0]        o_tag;
  logic [ANGLE_BITS-1:0] o_az, o_el;
  logic [41:0]        o_meas;
  logic signed [RXW-1:0] o_rx;
  logic               o_ovf, o_det, o_last;

  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;
  assign ack      = eng_done && (!m_tvalid || m_tready);

  assign dx = DW'($signed(s_tdata[32 +: POSITION_BITS])) -
              DW'($signed(s_tdata[152 +: POSITION_BITS]));
  assign dy = DW'($signed(s_tdata[72 +: POSITION_BITS])) -
              DW'($signed(s_tdata[192 +: POSITION_BITS]));
  assign dz = DW'($signed(s_tdata[112 +: POSITION_BITS])) -
              DW'($signed(s_tdata[232 +: POSITION_BITS]));

  assign hits_new = (eng_res.det && (hits != HITS_MAX)) ? hits + 33'd1 : hits;

  eilb_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .dx_in      (dx),
    .dy_in      (dy),
    .dz_in      (dz),
    .carrier_in (s_tdata[311:272]),
    .tx_in      (s_tdata[351:312]),
    .sens_in    (sens),
    .ack        (ack),
    .done       (eng_done),
    .res        (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sens   <= -18'sd25600;
      offset <= '0;
      cap    <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENS:   sens   <= $signed(cfg_wdata[17:0]);
        REG_OFFSET: offset <= $signed(cfg_wdata);
        REG_CAP:    cap    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      hits     <= '0;
    end else begin
      if (start) busy <= 1'b1;
      else if (ack) busy <= 1'b0;
      if (ack) begin
        m_tvalid <= 1'b1;
        hits     <= last ? '0 : hits_new;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // hold the pass-through fields of the transaction in flight and load the output register on ack
  always_ff @(posedge clk) begin
    if (start) begin
      tag     <= s_tdata[31:0];
      carrier <= s_tdata[311:272];
      last    <= s_tlast;
    end
    if (ack) begin
      o_tag  <= tag;
      o_det  <= eng_res.det;
      o_az   <= eng_res.az;
      o_el   <= eng_res.el;
      o_rx   <= eng_res.rx;
      o_meas <= eng_res.det ? (42'(carrier) + 42'(offset)) : '0;
      o_last <= last;
      o_ovf  <= last && (hits_new > 33'(cap));
    end
  end

  assign m_tdata = {3'b0, o_ovf, o_rx, o_meas, o_el, o_az, o_tag};
  assign m_tuser = o_det;
  assign m_tlast = o_last;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the emitter intercept link budget core.
// ----------------------------------------------------------------------------
// Emitters are queued by the stimulus process and sent by a clocked driver.
// An in-bench link budget calculator predicts each result, and a clocked
// monitor compares every result transaction with the oldest prediction.
// Directed emitters come first, then random batches under three idling
// patterns, with the detection threshold, frequency bias and intercept
// capacity changed between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import eilb_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [31:0] tag;
    logic signed [39:0] ex, ey, ez, sx, sy, sz;
    logic [39:0] carrier, tx;
    logic last;
  } emitter_t;

  typedef struct {
    logic [31:0] tag;
    logic det;
    logic [15:0] az, el;
    logic [41:0] meas;
    logic [17:0] rx;
    logic bend, ovf;
  } intercept_t;

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [30:0] cfg_wdata;
  logic s_tvalid, s_tready, s_tlast;
  logic [351:0] s_tdata;
  logic m_tvalid, m_tready, m_tuser, m_tlast;
  logic [127:0] m_tdata;

  esm_intercept_link_budget_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // predictor state
  longint sens_level;
  longint bias_hz;
  longint capacity;
  longint hits;

  emitter_t pending_emitters[$];
  intercept_t expected_intercepts[$];
  int send_idle_pct, recv_idle_pct;
  int mismatches;
  longint cycles;

  localparam logic [31:0] ATAN_LUT [30] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};

  function automatic int msb_index(logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i;
    return n;
  endfunction

  function automatic longint lg_q16(logic [63:0] v);
    int n;
    logic [127:0] y;
    longint frac;
    n = msb_index(v);
    y = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
    frac = 0;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= 128'h80000000) begin
        frac |= longint'(1) << i;
        y >>= 1;
      end
    end
    return longint'(n) * 65536 + frac;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] vector_angle(longint y, longint x);
    logic [31:0] acc;
    longint m, xs, ys;
    int n;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x == 0) return y > 0 ? 32'h40000000 : 32'hC0000000;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h80000000;
    end
    m = x > (y < 0 ? -y : y) ? x : (y < 0 ? -y : y);
    n = msb_index(m);
    if (n > 29) begin
      x = x >>> (n - 29);
      y = y >>> (n - 29);
    end else begin
      x = x <<< (29 - n);
      y = y <<< (29 - n);
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; acc += ATAN_LUT[i];
      end else begin
        x -= ys; y += xs; acc -= ATAN_LUT[i];
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] binary_angle(logic [31:0] acc);
    logic [31:0] s;
    s = acc + (32'd1 << 15);
    return s[31:16];
  endfunction

  function automatic intercept_t predict_intercept(emitter_t e);
    intercept_t r;
    longint dx, dy, dz, ax, ay, azm, m, lg, p, rl, zc;
    logic [63:0] a, b, c, sq;
    int t;
    r = '{tag: e.tag, det: 0, az: 0, el: 0, meas: 0, rx: 0, bend: e.last, ovf: 0};
    dx = longint'(e.ex) - longint'(e.sx);
    dy = longint'(e.ey) - longint'(e.sy);
    dz = longint'(e.ez) - longint'(e.sz);
    if (e.carrier != 0 && e.tx != 0 && (dx != 0 || dy != 0 || dz != 0)) begin
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      azm = dz < 0 ? -dz : dz;
      m = ax > ay ? ax : ay;
      if (azm > m) m = azm;
      t = 30 - msb_index(m);
      if (t >= 0) begin
        a = ax << t; b = ay << t; c = azm << t;
      end else begin
        a = ax >> -t; b = ay >> -t; c = azm >> -t;
      end
      sq = a * a + b * b + c * c;
      lg = lg_q16(e.tx) - (lg_q16(sq) - longint'(t) * 2 * 65536) - 2 * lg_q16(e.carrier);
      p = 45453 + ((lg * 50504453 + (longint'(1) << 31)) >>> 32);
      if (p >= sens_level) begin
        rl = p < -102400 ? -102400 : (p > 51200 ? 51200 : p);
        zc = dz < 0 ? -longint'(c) : longint'(c);
        r.det = 1;
        r.az = binary_angle(vector_angle(dy, dx));
        r.el = binary_angle(vector_angle(zc, longint'(int_sqrt(a * a + b * b))));
        r.meas = 42'(longint'(e.carrier) + bias_hz);
        r.rx = 18'(rl);
        if (hits < 64'h1FFFFFFFF) hits++;
      end
    end
    if (e.last) begin
      r.ovf = hits > capacity;
      hits = 0;
    end
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_emitters.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        emitter_t e;
        e = pending_emitters.pop_front();
        expected_intercepts = {expected_intercepts, predict_intercept(e)};
        s_tdata <= {e.tx, e.carrier, e.sz, e.sy, e.sx, e.ez, e.ey, e.ex, e.tag};
        s_tlast <= e.last;
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        intercept_t w, g;
        g.tag = m_tdata[31:0];
        g.az = m_tdata[47:32];
        g.el = m_tdata[63:48];
        g.meas = m_tdata[105:64];
        g.rx = m_tdata[123:106];
        g.ovf = m_tdata[124];
        g.det = m_tuser;
        g.bend = m_tlast;
        if (expected_intercepts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result tag %h", g.tag);
        end else begin
          w = expected_intercepts.pop_front();
          if (w.tag !== g.tag || w.det !== g.det || w.az !== g.az || w.el !== g.el ||
              w.meas !== g.meas || w.rx !== g.rx || w.bend !== g.bend || w.ovf !== g.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp tag %h det %b az %h el %h hz %h rx %h end %b ovf %b\n",
                       w.tag, w.det, w.az, w.el, w.meas, w.rx, w.bend, w.ovf,
                       "         got tag %h det %b az %h el %h hz %h rx %h end %b ovf %b",
                       g.tag, g.det, g.az, g.el, g.meas, g.rx, g.bend, g.ovf);
          end
        end
      end
      m_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_SENS: sens_level = longint'(signed'(val[17:0]));
      REG_OFFSET: bias_hz = longint'(signed'(val));
      REG_CAP: capacity = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_emitters.size() > 0 || expected_intercepts.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic signed [39:0] rand_pos(int span);
    logic signed [39:0] v;
    case ($urandom_range(3))
      0: v = 40'({$urandom, $urandom});
      1: v = $signed(40'($urandom_range(2 * span))) - span;
      2: v = $urandom_range(1) ? 40'sh7FFFFFFFFF : 40'sh8000000000;
      default: v = $signed(40'($urandom_range(1000000))) - 500000;
    endcase
    return v;
  endfunction

  function automatic logic [39:0] rand_mag();
    logic [39:0] v;
    v = 40'({$urandom, $urandom});
    return v >> $urandom_range(39);
  endfunction

  task automatic queue_emitter(logic signed [39:0] ex, ey, ez, sx, sy, sz,
                               logic [39:0] car, tx, logic last);
    emitter_t e;
    e = '{tag: $urandom, ex: ex, ey: ey, ez: ez, sx: sx, sy: sy, sz: sz,
          carrier: car, tx: tx, last: last};
    pending_emitters = {pending_emitters, e};
  endtask

  task automatic random_batches(int count);
    logic signed [39:0] sx, sy, sz;
    int n;
    while (count > 0) begin
      sx = rand_pos(100000); sy = rand_pos(100000); sz = rand_pos(100000);
      n = $urandom_range(1, 8);
      for (int i = 0; i < n && count > 0; i++) begin
        // most emitters near the sensor with strong power so detections happen
        if ($urandom_range(9) < 7)
          queue_emitter(sx + $signed(40'($urandom_range(200000))) - 100000,
                        sy + $signed(40'($urandom_range(200000))) - 100000,
                        sz + $signed(40'($urandom_range(200000))) - 100000,
                        sx, sy, sz,
                        40'($urandom_range(1, 32'hFFFFFFFF)),
                        $urandom_range(4) == 0 ? rand_mag() | 40'd1
                                               : rand_mag() | 40'h1000000,
                        i == n - 1 || count == 1);
        else
          queue_emitter(rand_pos(1 << 30), rand_pos(1 << 30), rand_pos(1 << 30),
                        $urandom_range(1) ? sx : rand_pos(100), sy, sz,
                        $urandom_range(7) == 0 ? 40'd0 : rand_mag(),
                        $urandom_range(7) == 0 ? 40'd0 : rand_mag(),
                        i == n - 1 || count == 1);
        count--;
      end
    end
    drain();
  endtask

  initial begin
    rst = 1;
    cfg_we = 0; cfg_index = REG_SENS; cfg_wdata = 0;
    s_tvalid = 0; s_tdata = '0; s_tlast = 0; m_tready = 0;
    sens_level = -25600; bias_hz = 0; capacity = 65535; hits = 0;
    mismatches = 0; cycles = 0;
    send_idle_pct = 16; recv_idle_pct = 46;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: drops, extremes, axes, half turn and straight up
    write_reg(REG_SENS, 31'(-102400));
    queue_emitter(100, 0, 0, 0, 0, 0, 0, 1000, 0);
    queue_emitter(100, 0, 0, 0, 0, 0, 1000, 0, 0);
    queue_emitter(5, 5, 5, 5, 5, 5, 1000, 1000, 1);
    queue_emitter(1, 0, 0, 0, 0, 0, 40'd1, 40'hFFFFFFFFFF, 0);
    queue_emitter(40'sh7FFFFFFFFF, 40'sh7FFFFFFFFF, 40'sh7FFFFFFFFF,
                  40'sh8000000000, 40'sh8000000000, 40'sh8000000000,
                  40'hFFFFFFFFFF, 40'd1, 0);
    queue_emitter(-1000, 0, 0, 0, 0, 0, 1000, 1000000, 0);
    queue_emitter(0, 1000, 0, 0, 0, 0, 1000, 1000000, 0);
    queue_emitter(0, -1000, 0, 0, 0, 0, 1000, 1000000, 0);
    queue_emitter(0, 0, 1000, 0, 0, 0, 1000, 1000000, 0);
    queue_emitter(0, 0, -1000, 0, 0, 0, 1000, 1000000, 0);
    queue_emitter(-7, -7, 3, 0, 0, 0, 40'hFFFFFFFFFF, 40'hFFFFFFFFFF, 1);
    queue_emitter(40'sh8000000000, 40'sh7FFFFFFFFF, 0, 40'sh7FFFFFFFFF,
                  40'sh8000000000, 0, 1000000000, 1000000, 1);
    drain();
    write_reg(REG_CAP, 0);
    queue_emitter(10, 10, 10, 0, 0, 0, 1000, 1000000, 0);
    queue_emitter(10, -10, 10, 0, 0, 0, 1000, 1000000, 1);
    queue_emitter(10, 10, 10, 0, 0, 0, 40'hFFFFFFFFFF, 1, 1);
    drain();

    write_reg(REG_SENS, 31'(-25600));
    write_reg(REG_OFFSET, 31'h3FFFFFFF);
    write_reg(REG_CAP, 3);
    random_batches(320);

    send_idle_pct = 46; recv_idle_pct = 16;
    write_reg(REG_SENS, 31'(51200));
    write_reg(REG_OFFSET, 31'h40000000);
    write_reg(REG_CAP, 65535);
    write_reg(REG_UNUSED, 31'h7FFFFFFF);
    random_batches(150);
    write_reg(REG_SENS, 31'(-102400));
    write_reg(REG_CAP, 1);
    random_batches(160);

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_SENS, 31'(-40000));
    write_reg(REG_OFFSET, 31'($urandom));
    write_reg(REG_CAP, 2);
    random_batches(320);

    if (mismatches == 0 && expected_intercepts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> esm_intercept_link_budget_core.f
hw/rtl/eilb_pkg.sv
hw/rtl/eilb_engine.sv
hw/rtl/esm_intercept_link_budget_core.sv
verif/testbench.sv
